[sv/clqgen_pkg.sv]
// shared types and constants for the clique clause literal generator
package clqgen_pkg;

	localparam int MAX_ORDER_DEF  = 64;
	localparam int MAX_SUBSET_DEF = 5;

	localparam int VCOUNT_W  = 7;
	localparam int KSIZE_W   = 3;
	localparam int LITERAL_W = 12;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 7'd5;
	localparam logic [KSIZE_W-1:0]  KSIZE_RST  = 3'd5;
	localparam logic [KSIZE_W-1:0]  KSIZE_SMALL = 3'd3;
	localparam logic [KSIZE_W-1:0]  KSIZE_LARGE = 3'd5;

	typedef enum logic [STATUS_W-1:0] {
		ST_LITERAL     = 2'd0,
		ST_DONE        = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_COUNT = 2'd0,
		REG_SUBSET_SIZE  = 2'd1
	} reg_idx_t;

	// control handed to every cell of the row
	typedef struct packed {
		logic                restart;
		logic                load;
		logic                init;
		logic                step;
		logic [KSIZE_W-1:0]  k;
		logic [VCOUNT_W-1:0] n_minus_k;
	} walk_ctl_t;

	typedef struct packed {
		logic signed [LITERAL_W-1:0] literal;
		logic                        clause_end;
		status_t                     status;
	} lit_item_t;

endpackage

[sv/clqgen_cell.sv]
// one subset position: holds a vertex, takes part in the carry and pair-select chains
module clqgen_cell #(
	parameter int VW  = 6,
	parameter int PW  = 3,
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clqgen_pkg::walk_ctl_t ctl,
	input  logic [PW-1:0]         pair_lo,
	input  logic [PW-1:0]         pair_hi,
	input  logic [VW-1:0]         lo_in,
	input  logic [VW-1:0]         hi_in,
	output logic [VW-1:0]         lo_out,
	output logic [VW-1:0]         hi_out,
	input  logic                  chg_in,
	input  logic [VW-1:0]         base_in,
	output logic                  chg_out,
	output logic [VW-1:0]         base_out,
	input  logic                  stuck_in,
	output logic                  stuck_out
);

	localparam int LW = ((VW > clqgen_pkg::VCOUNT_W) ? VW : clqgen_pkg::VCOUNT_W) + 1;

	logic [VW-1:0] v_q;
	logic [VW-1:0] v_eff;
	logic [VW-1:0] v_new;
	logic [LW-1:0] limit;
	logic          active;
	logic          can_inc;
	logic          inc;

	function automatic logic clique_idx_fits(input int i);
		clique_idx_fits = (i < 8);
	endfunction

	assign v_eff  = ctl.restart ? VW'(IDX) : v_q;
	assign active = (clique_idx_fits(IDX)) && (3'(IDX) < ctl.k);
	assign limit  = LW'(ctl.n_minus_k) + LW'(IDX);

	// largest value this position may take is n-k+position
	assign can_inc   = active && (LW'(v_eff) < limit);
	assign inc       = can_inc && stuck_in;
	assign stuck_out = stuck_in && !can_inc;

	always_comb begin
		if (inc) begin
			v_new = v_eff + VW'(1);
		end else if (chg_in) begin
			v_new = base_in + VW'(1);
		end else begin
			v_new = v_eff;
		end
	end

	assign chg_out  = chg_in || inc;
	assign base_out = v_new;

	assign lo_out = lo_in | ((pair_lo == PW'(IDX)) ? v_eff : '0);
	assign hi_out = hi_in | ((pair_hi == PW'(IDX)) ? v_eff : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= VW'(IDX);
		end else if (ctl.init) begin
			v_q <= VW'(IDX);
		end else if (ctl.load) begin
			v_q <= ctl.step ? v_new : v_eff;
		end
	end

endmodule

[sv/clqgen_out_buf.sv]
// output register with a skid entry so the request side sees only registered stall
module clqgen_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  clqgen_pkg::lit_item_t push_item,
	output logic                  full,
	input  logic                  out_stall,
	output logic                  out_valid,
	output clqgen_pkg::lit_item_t out_item
);

	logic                  main_valid_q;
	logic                  skid_valid_q;
	clqgen_pkg::lit_item_t main_q;
	clqgen_pkg::lit_item_t skid_q;
	logic                  pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_valid_q || pop) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end
	end

endmodule

[sv/clique_clause_literal_generator_top.sv]
// clique clause literal generator: k-subset walk and edge literal stream
// Every accepted request gives one literal item, and a new request can be taken in every
// cycle while req_stall is low. A row of MAX_SUBSET cells holds the current subset; the
// step to the next subset ripples through that row in the same cycle as the last literal
// of the negative clause, so that rate holds across subsets too. The result side has an
// output register that drives the lit channel, plus one skid entry: req_stall rises only
// when both hold items the lit side has not taken. Writing vertex_count or the subset size
// restarts the walk at the first subset; cfg_ready is always high and writes are meant for
// an idle block. An unsupported n/k gives status 2 items, and after the last subset every
// request gives status 1 until a restart or a write.
module clique_clause_literal_generator_top #(
	parameter int MAX_ORDER  = clqgen_pkg::MAX_ORDER_DEF,
	parameter int MAX_SUBSET = clqgen_pkg::MAX_SUBSET_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [clqgen_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [clqgen_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                     req_valid,
	output logic                                     req_stall,
	input  logic                                     restart,
	output logic                                     lit_valid,
	input  logic                                     lit_stall,
	output logic signed [clqgen_pkg::LITERAL_W-1:0]  literal,
	output logic                                     clause_end,
	output logic [clqgen_pkg::STATUS_W-1:0]          status
);

	localparam int VW   = $clog2(MAX_ORDER);
	localparam int PW   = $clog2(MAX_SUBSET);
	localparam int VARW = (2 * VW + 1 > clqgen_pkg::LITERAL_W) ? 2 * VW + 1 : clqgen_pkg::LITERAL_W;
	// pair index arithmetic: indices stay below 5, so 4 bits never overflow
	localparam int SW   = 4;
	localparam logic [8:0] ORDER_LIMIT = 9'(MAX_ORDER);
	localparam logic [clqgen_pkg::KSIZE_W-1:0] SUBSET_LIMIT = clqgen_pkg::KSIZE_W'(MAX_SUBSET);

	logic [clqgen_pkg::VCOUNT_W-1:0] vertex_count_q;
	logic [clqgen_pkg::KSIZE_W-1:0]  subset_size_q;
	logic [PW-1:0]                   pair_first_q;
	logic [PW-1:0]                   pair_second_q;
	logic                            colour_q;
	logic                            finished_q;

	logic                  accept;
	logic                  cfg_we;
	logic                  walk_init;
	logic                  cfg_ok;
	logic                  emit;
	logic [PW-1:0]         pf_eff;
	logic [PW-1:0]         ps_eff;
	logic                  colour_eff;
	logic                  finished_eff;
	logic [PW-1:0]         pf_next;
	logic [PW-1:0]         ps_next;
	logic                  colour_next;
	logic                  clause_last;
	logic [SW-1:0]         k_w;
	logic [SW-1:0]         ps1;
	logic [SW-1:0]         pf1;
	logic [SW-1:0]         ps2;
	clqgen_pkg::walk_ctl_t ctl;
	clqgen_pkg::lit_item_t item;
	clqgen_pkg::lit_item_t out_item;

	logic [VW-1:0] lo_c   [MAX_SUBSET+1];
	logic [VW-1:0] hi_c   [MAX_SUBSET+1];
	logic [VW-1:0] base_c [MAX_SUBSET+1];
	logic          chg_c  [MAX_SUBSET+1];
	logic          stuck_c[MAX_SUBSET+1];

	logic [VW-1:0]     lo_v;
	logic [VW-1:0]     hi_v;
	logic [2*VW-1:0]   tri_prod;
	logic [VARW-1:0]   edge_var;
	logic [VARW-1:0]   signed_var;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		walk_init = 1'b0;
		if (cfg_we) begin
			unique case (cfg_index) inside
				clqgen_pkg::REG_VERTEX_COUNT,
				clqgen_pkg::REG_SUBSET_SIZE: walk_init = 1'b1;
				default:                     walk_init = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= clqgen_pkg::VCOUNT_RST;
			subset_size_q  <= clqgen_pkg::KSIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clqgen_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				clqgen_pkg::REG_SUBSET_SIZE:  subset_size_q  <= cfg_data[clqgen_pkg::KSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ok = ((subset_size_q == clqgen_pkg::KSIZE_SMALL) ||
	                 (subset_size_q == clqgen_pkg::KSIZE_LARGE)) &&
	                (subset_size_q <= SUBSET_LIMIT) &&
	                (vertex_count_q != '0) &&
	                (9'(vertex_count_q) <= ORDER_LIMIT) &&
	                (7'(subset_size_q) <= vertex_count_q);

	// restart takes effect before the literal of this item is formed
	assign pf_eff       = restart ? '0 : pair_first_q;
	assign ps_eff       = restart ? PW'(1) : pair_second_q;
	assign colour_eff   = restart ? 1'b0 : colour_q;
	assign finished_eff = restart ? 1'b0 : finished_q;

	assign emit = cfg_ok && !finished_eff;

	assign k_w = SW'(subset_size_q);
	assign ps1 = SW'(ps_eff) + SW'(1);
	assign pf1 = SW'(pf_eff) + SW'(1);
	assign ps2 = pf1 + SW'(1);

	always_comb begin
		clause_last = 1'b0;
		pf_next     = pf_eff;
		ps_next     = PW'(ps1);
		colour_next = colour_eff;
		if (ps1 >= k_w) begin
			if (ps2 >= k_w) begin
				clause_last = 1'b1;
				pf_next     = '0;
				ps_next     = PW'(1);
				colour_next = !colour_eff;
			end else begin
				pf_next = PW'(pf1);
				ps_next = PW'(ps2);
			end
		end
	end

	always_comb begin
		ctl.restart   = restart;
		ctl.load      = accept;
		ctl.init      = walk_init;
		ctl.step      = emit && clause_last && colour_eff;
		ctl.k         = subset_size_q;
		ctl.n_minus_k = vertex_count_q - 7'(subset_size_q);
	end

	assign lo_c[0]             = '0;
	assign hi_c[0]             = '0;
	assign chg_c[0]            = 1'b0;
	assign base_c[0]           = '0;
	assign stuck_c[MAX_SUBSET] = 1'b1;

	for (genvar p = 0; p < MAX_SUBSET; p++) begin : g_cell
		clqgen_cell #(
			.VW (VW),
			.PW (PW),
			.IDX(p)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.pair_lo  (pf_eff),
			.pair_hi  (ps_eff),
			.lo_in    (lo_c[p]),
			.hi_in    (hi_c[p]),
			.lo_out   (lo_c[p+1]),
			.hi_out   (hi_c[p+1]),
			.chg_in   (chg_c[p]),
			.base_in  (base_c[p]),
			.chg_out  (chg_c[p+1]),
			.base_out (base_c[p+1]),
			.stuck_in (stuck_c[p+1]),
			.stuck_out(stuck_c[p])
		);
	end

	always_comb begin
		if (lo_c[MAX_SUBSET] > hi_c[MAX_SUBSET]) begin
			lo_v = hi_c[MAX_SUBSET];
			hi_v = lo_c[MAX_SUBSET];
		end else begin
			lo_v = lo_c[MAX_SUBSET];
			hi_v = hi_c[MAX_SUBSET];
		end
	end

	// triangular edge number hi*(hi-1)/2 + lo + 1; hi of zero gives a zero product
	assign tri_prod   = (2*VW)'(hi_v) * (2*VW)'(hi_v - VW'(1));
	assign edge_var   = VARW'(tri_prod >> 1) + VARW'(lo_v) + VARW'(1);
	assign signed_var = colour_eff ? (VARW'(0) - edge_var) : edge_var;

	always_comb begin
		if (!cfg_ok) begin
			item.literal    = '0;
			item.clause_end = 1'b0;
			item.status     = clqgen_pkg::ST_UNSUPPORTED;
		end else if (finished_eff) begin
			item.literal    = '0;
			item.clause_end = 1'b0;
			item.status     = clqgen_pkg::ST_DONE;
		end else begin
			item.literal    = signed_var[clqgen_pkg::LITERAL_W-1:0];
			item.clause_end = clause_last;
			item.status     = clqgen_pkg::ST_LITERAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_first_q  <= '0;
			pair_second_q <= PW'(1);
			colour_q      <= 1'b0;
			finished_q    <= 1'b0;
		end else if (walk_init) begin
			pair_first_q  <= '0;
			pair_second_q <= PW'(1);
			colour_q      <= 1'b0;
			finished_q    <= 1'b0;
		end else if (accept) begin
			if (emit) begin
				pair_first_q  <= pf_next;
				pair_second_q <= ps_next;
				colour_q      <= colour_next;
				finished_q    <= ctl.step ? stuck_c[0] : 1'b0;
			end else begin
				pair_first_q  <= pf_eff;
				pair_second_q <= ps_eff;
				colour_q      <= colour_eff;
				finished_q    <= finished_eff;
			end
		end
	end

	clqgen_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(item),
		.full     (req_stall),
		.out_stall(lit_stall),
		.out_valid(lit_valid),
		.out_item (out_item)
	);

	assign literal    = out_item.literal;
	assign clause_end = out_item.clause_end;
	assign status     = out_item.status;

endmodule

[sv/clqgen_check.sv]
// port-level checks for the clique clause literal generator, bound to the top level
module clqgen_check (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    cfg_valid,
	input logic                                    cfg_ready,
	input logic [clqgen_pkg::CFG_IDX_W-1:0]        cfg_index,
	input logic [clqgen_pkg::CFG_DATA_W-1:0]       cfg_data,
	input logic                                    req_valid,
	input logic                                    req_stall,
	input logic                                    restart,
	input logic                                    lit_valid,
	input logic                                    lit_stall,
	input logic signed [clqgen_pkg::LITERAL_W-1:0] literal,
	input logic                                    clause_end,
	input logic [clqgen_pkg::STATUS_W-1:0]         status
);

	// an accepted request always leaves an item on the result side
	a_accept_gives_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> lit_valid)
		else $error("accepted request produced no item");

	// the request side only stalls while results are backed up
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> lit_valid)
		else $error("request stalled with no pending item");

	// status items carry no literal and no end mark
	a_status_item_empty: assert property (@(posedge clk) disable iff (!arst_n)
		lit_valid && (status != clqgen_pkg::ST_LITERAL) |-> (literal == '0) && !clause_end)
		else $error("status item carries literal data");

	a_held_item_stable: assert property (@(posedge clk) disable iff (!arst_n)
		lit_valid && lit_stall |=> lit_valid && $stable(literal) && $stable(clause_end) &&
		$stable(status))
		else $error("stalled item changed");

endmodule

bind clique_clause_literal_generator_top clqgen_check u_clqgen_check (.*);

[tb/testbench.sv]
// testbench for the clique clause literal generator: literal stream vs predicted walk
`timescale 1ns / 100ps

module testbench;
	import clqgen_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int RANDOM_ITEMS = 1800;
	localparam int MAX_WAIT = 12;

	// predicts the literal stream and holds the literals still to come
	class clause_scoreboard;
		logic [VCOUNT_W-1:0] vcount;
		logic [KSIZE_W-1:0] ksize;
		int unsigned members[8];
		bit colour;
		int unsigned pair_a;
		int unsigned pair_b;
		bit walk_done;
		lit_item_t expected_literals[$];
		int errors;

		function new();
			vcount = VCOUNT_RST;
			ksize = KSIZE_RST;
			errors = 0;
			rewind();
		endfunction

		function void rewind();
			for (int i = 0; i < 8; i++)
				members[i] = i;
			colour = 1'b0;
			pair_a = 0;
			pair_b = 1;
			walk_done = 1'b0;
		endfunction

		function bit supported();
			return (ksize == KSIZE_SMALL || ksize == KSIZE_LARGE) && vcount >= 1 &&
				vcount <= MAX_ORDER_DEF && ksize <= vcount;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_VERTEX_COUNT: begin
					vcount = data;
					rewind();
				end
				REG_SUBSET_SIZE: begin
					ksize = data[KSIZE_W-1:0];
					rewind();
				end
				default: ;
			endcase
		endfunction

		// lexicographic successor of the current subset
		function void advance_subset();
			int n;
			int k;
			n = int'(vcount);
			k = int'(ksize);
			for (int p = k - 1; p >= 0; p--) begin
				if (members[p] < n - k + p) begin
					members[p]++;
					for (int j = p + 1; j < k; j++)
						members[j] = members[p] + (j - p);
					return;
				end
			end
			walk_done = 1'b1;
		endfunction

		function void note_request(bit rs);
			lit_item_t e;
			int lo;
			int hi;
			int var_idx;
			if (rs)
				rewind();
			e.literal = '0;
			e.clause_end = 1'b0;
			if (!supported()) begin
				e.status = ST_UNSUPPORTED;
			end else if (walk_done) begin
				e.status = ST_DONE;
			end else begin
				lo = members[pair_a];
				hi = members[pair_b];
				var_idx = hi * (hi - 1) / 2 + lo + 1;
				e.literal = colour ? LITERAL_W'(-var_idx) : LITERAL_W'(var_idx);
				e.status = ST_LITERAL;
				pair_b++;
				if (pair_b >= ksize) begin
					pair_a++;
					pair_b = pair_a + 1;
					if (pair_b >= ksize) begin
						e.clause_end = 1'b1;
						pair_a = 0;
						pair_b = 1;
						if (colour) begin
							colour = 1'b0;
							advance_subset();
						end else begin
							colour = 1'b1;
						end
					end
				end
			end
			expected_literals.push_back(e);
		endfunction

		function void check_literal(logic signed [LITERAL_W-1:0] lit, logic ce,
				logic [STATUS_W-1:0] st);
			lit_item_t e;
			if (expected_literals.size() == 0) begin
				$error("literal item with none expected: literal %0d status %0d", lit, st);
				errors++;
				return;
			end
			e = expected_literals.pop_front();
			if (lit !== e.literal) begin
				$error("literal: expected %0d, actual %0d", e.literal, lit);
				errors++;
			end
			if (ce !== e.clause_end) begin
				$error("clause_end: expected %0d, actual %0d", e.clause_end, ce);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return expected_literals.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic restart = 1'b0;
	logic lit_valid;
	logic lit_stall = 1'b1;
	logic signed [LITERAL_W-1:0] literal;
	logic clause_end;
	logic [STATUS_W-1:0] status;

	clause_scoreboard sb = new();
	bit req_eager = 1'b0;
	bit lit_eager = 1'b0;

	clique_clause_literal_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.restart(restart),
		.lit_valid(lit_valid),
		.lit_stall(lit_stall),
		.literal(literal),
		.clause_end(clause_end),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// sender: random gap, then hold the item until taken
	task automatic send_request(bit rs);
		int gap;
		gap = req_eager ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (req_stall);
		sb.note_request(rs);
	endtask

	// cfg_valid is dropped after each write so that back-to-back writes stay apart
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// drop the request line and let every outstanding item drain
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// receiver: stall for a random stretch before each item
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = lit_eager ? 0 : $urandom_range(0, MAX_WAIT);
			if (w > 0) begin
				lit_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			lit_stall <= 1'b0;
			do @(posedge clk); while (!lit_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && lit_valid && !lit_stall)
			sb.check_literal(literal, clause_end, status);
	end

	initial begin
		int random_items;
		int r;
		int cnt;
		logic [VCOUNT_W-1:0] n_val;
		logic [KSIZE_W-1:0] k_val;
		random_items = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 5-of-5: both clauses of the single subset, then finished, then restart
		for (int i = 0; i < 22; i++)
			send_request(1'b0);
		send_request(1'b1);
		settle();
		write_cfg(REG_VERTEX_COUNT, 7'd0);
		send_request(1'b0);
		settle();
		write_cfg(REG_VERTEX_COUNT, 7'd127);
		send_request(1'b1);
		settle();
		write_cfg(REG_SPARE_HI, 7'h7f);
		write_cfg(REG_SPARE_LO, 7'h55);

		while (random_items < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(0, 99);
			if (r < 40) begin
				k_val = KSIZE_SMALL;
				n_val = VCOUNT_W'($urandom_range(3, 8));
			end else if (r < 65) begin
				k_val = KSIZE_LARGE;
				n_val = VCOUNT_W'($urandom_range(5, 7));
			end else if (r < 75) begin
				k_val = $urandom_range(0, 1) ? KSIZE_SMALL : KSIZE_LARGE;
				n_val = VCOUNT_W'($urandom_range(60, MAX_ORDER_DEF));
			end else if (r < 88) begin
				do k_val = KSIZE_W'($urandom_range(0, 7));
				while (k_val == KSIZE_SMALL || k_val == KSIZE_LARGE);
				n_val = VCOUNT_W'($urandom_range(0, 127));
			end else begin
				k_val = $urandom_range(0, 1) ? KSIZE_SMALL : KSIZE_LARGE;
				case ($urandom_range(0, 2))
					0: n_val = 7'd0;
					1: n_val = VCOUNT_W'($urandom_range(0, k_val - 1));
					default: n_val = VCOUNT_W'($urandom_range(MAX_ORDER_DEF + 1, 127));
				endcase
			end
			// upper data bits are don't-care for the size register
			if ($urandom_range(0, 1)) begin
				write_cfg(REG_VERTEX_COUNT, n_val);
				write_cfg(REG_SUBSET_SIZE, {4'($urandom_range(0, 15)), k_val});
			end else begin
				write_cfg(REG_SUBSET_SIZE, {4'($urandom_range(0, 15)), k_val});
				write_cfg(REG_VERTEX_COUNT, n_val);
			end
			if ($urandom_range(0, 7) == 0)
				write_cfg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_DATA_W'($urandom_range(0, 127)));
			req_eager = ($urandom_range(0, 4) == 0);
			lit_eager = ($urandom_range(0, 4) == 0);
			cnt = sb.supported() ? $urandom_range(20, 200) : $urandom_range(3, 15);
			for (int i = 0; i < cnt; i++) begin
				send_request($urandom_range(0, 49) == 0);
				random_items++;
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
sv/clqgen_pkg.sv
sv/clqgen_cell.sv
sv/clqgen_out_buf.sv
sv/clique_clause_literal_generator_top.sv
sv/clqgen_check.sv
tb/testbench.sv
